>>> rtl/core/rqr_pkg.sv
package rqr_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_BURSTS_DEF  = 4;

	localparam int ID_W     = 16;
	localparam int PROG_W   = 12;
	localparam int LVL_W    = 3;
	localparam int CNT_IN_W = 4;
	localparam int CNT_W    = 3;
	localparam int BURST_W  = 10;
	localparam int NBURST   = 4;
	localparam int TIO_W    = 17;
	localparam int OCC_W    = 5;
	localparam int OP_W     = 2;
	localparam int STS_W    = 3;
	localparam int IN_W     = 80;
	localparam int OUT_W    = 96;

	localparam logic [TIO_W-1:0] NO_IO_TIME = 17'd100000;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_REINSERT = 2'd1,
		OP_RETRIEVE = 2'd2,
		OP_REMOVE   = 2'd3
	} op_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK       = 3'd0,
		STS_EMPTY    = 3'd1,
		STS_FULL     = 3'd2,
		STS_NOTFOUND = 3'd3,
		STS_BURSTS   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [NBURST-1:0][BURST_W-1:0] bursts;
		logic [CNT_W-1:0]               burst_count;
		logic [LVL_W-1:0]               level_id;
		logic [PROG_W-1:0]              progress;
		logic [ID_W-1:0]                proc_id;
	} entry_t;

	typedef struct packed {
		logic [4:0]          pad;
		logic [BURST_W-1:0]  burst_d;
		logic [BURST_W-1:0]  burst_c;
		logic [BURST_W-1:0]  burst_b;
		logic [BURST_W-1:0]  burst_a;
		logic [CNT_IN_W-1:0] burst_count;
		logic [LVL_W-1:0]    level_id;
		logic [PROG_W-1:0]   progress;
		logic [ID_W-1:0]     proc_id;
	} in_data_t;

	typedef struct packed {
		logic [OCC_W-1:0]   occupancy;
		logic [TIO_W-1:0]   time_to_io;
		logic [BURST_W-1:0] out_burst_d;
		logic [BURST_W-1:0] out_burst_c;
		logic [BURST_W-1:0] out_burst_b;
		logic [BURST_W-1:0] out_burst_a;
		logic [CNT_W-1:0]   out_burst_count;
		logic [LVL_W-1:0]   out_level_id;
		logic [PROG_W-1:0]  out_progress;
		logic [ID_W-1:0]    out_proc_id;
	} out_data_t;

	typedef struct packed {
		status_t          status;
		entry_t           ent;
		logic [TIO_W-1:0] tio;
	} res_t;

endpackage

>>> rtl/core/ready_queue_with_removal_core.sv
// Insert, reinsert and any refused command go straight to the response step; retrieve
// first reads the head entry; remove scans from the head for the id and, unless the match
// is the last entry, moves each later entry one slot back to close the gap.
// One item at a time; the entry memory moves one entry per cycle in scan and compaction.
// A new word is taken while the last result waits. Reset clears the count, head pointer
// and control; memory is not cleared.
module ready_queue_with_removal_core
	import rqr_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int MAX_BURSTS  = MAX_BURSTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// proc_id, progress, level_id, burst_count, burst_a, burst_b, burst_c, burst_d
	input  logic [IN_W-1:0]  s_tdata,
	// operation
	input  logic [OP_W-1:0]  s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// out_proc_id, out_progress, out_level_id, out_burst_count, out_burst_a,
	// out_burst_b, out_burst_c, out_burst_d, time_to_io, occupancy
	output logic [OUT_W-1:0] m_tdata,
	// status
	output logic [STS_W-1:0] m_tuser
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + (AW+1)'(off);
		if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (AW+1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	state_t         state_q, state_d;
	logic [AW-1:0]  head_q, head_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  rd_off_q, rd_off_d;
	logic [CW-1:0]  wr_off_q, wr_off_d;
	logic           cmp_s1, cmp_d;
	logic [CW-1:0]  cmp_off_s1, cmp_off_d;
	logic           sh_s1, sh_d;
	logic [ID_W-1:0] id_q, id_d;
	res_t           res_q, res_d;
	logic           m_tvalid_q, load_out;
	logic [OUT_W-1:0] m_tdata_q;
	logic [STS_W-1:0] m_tuser_q;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	entry_t         mem_wdata;
	entry_t         rd_data;
	logic [AW-1:0]  rd_addr;
	logic [TIO_W-1:0] tio;

	in_data_t       in_w;
	op_t            in_op;
	logic [NBURST-1:0][BURST_W-1:0] in_bursts;
	entry_t         new_ent;
	out_data_t      out_w;

	assign in_w      = in_data_t'(s_tdata);
	assign in_op     = op_t'(s_tuser);
	assign in_bursts = {in_w.burst_d, in_w.burst_c, in_w.burst_b, in_w.burst_a};
	assign rd_addr   = phys(head_q, rd_off_q);
	assign s_tready  = (state_q == S_IDLE);

	always_comb begin
		new_ent.proc_id     = in_w.proc_id;
		new_ent.progress    = (in_op == OP_REINSERT) ? in_w.progress : '0;
		new_ent.level_id    = in_w.level_id;
		new_ent.burst_count = in_w.burst_count[CNT_W-1:0];
		for (int k = 0; k < NBURST; k++) begin
			new_ent.bursts[k] = (CNT_IN_W'(k) < in_w.burst_count) ? in_bursts[k] : '0;
		end
	end

	rqr_mem #(
		.DEPTH(QUEUE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	rqr_tio u_tio (
		.ent(rd_data),
		.tio(tio)
	);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		rd_off_d   = rd_off_q;
		wr_off_d   = wr_off_q;
		cmp_d      = cmp_s1;
		cmp_off_d  = cmp_off_s1;
		sh_d       = sh_s1;
		id_d       = id_q;
		res_d      = res_q;
		mem_we     = 1'b0;
		mem_waddr  = phys(head_q, wr_off_q);
		mem_wdata  = rd_data;
		load_out   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					id_d         = in_w.proc_id;
					res_d        = '0;
					res_d.status = STS_OK;
					case (in_op)
						OP_INSERT, OP_REINSERT: begin
							if (in_w.burst_count > CNT_IN_W'(MAX_BURSTS)) begin
								res_d.status = STS_BURSTS;
							end else if (count_q >= CW'(QUEUE_DEPTH)) begin
								res_d.status = STS_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = phys(head_q, count_q);
								mem_wdata = new_ent;
								count_d   = count_q + CW'(1);
							end
							state_d = S_RESP;
						end
						OP_RETRIEVE: begin
							if (count_q == '0) begin
								res_d.status = STS_EMPTY;
								state_d      = S_RESP;
							end else begin
								state_d = S_POP;
							end
						end
						default: begin
							// remove by id: the head is being read this cycle
							if (count_q == '0) begin
								res_d.status = STS_EMPTY;
								state_d      = S_RESP;
							end else begin
								rd_off_d  = CW'(1);
								cmp_d     = 1'b1;
								cmp_off_d = '0;
								state_d   = S_SCAN;
							end
						end
					endcase
				end
			end
			S_POP: begin
				res_d.ent = rd_data;
				res_d.tio = tio;
				head_d    = phys(head_q, CW'(1));
				count_d   = count_q - CW'(1);
				state_d   = S_RESP;
			end
			S_SCAN: begin
				if (cmp_s1 && (rd_data.proc_id == id_q)) begin
					res_d.ent.proc_id = id_q;
					if (cmp_off_s1 == count_q - CW'(1)) begin
						count_d = count_q - CW'(1);
						state_d = S_RESP;
					end else begin
						wr_off_d = cmp_off_s1;
						rd_off_d = cmp_off_s1 + CW'(1);
						sh_d     = 1'b0;
						state_d  = S_SHIFT;
					end
				end else if (cmp_s1 && (cmp_off_s1 == count_q - CW'(1))) begin
					res_d.status = STS_NOTFOUND;
					state_d      = S_RESP;
				end else begin
					cmp_d     = (rd_off_q < count_q);
					cmp_off_d = rd_off_q;
					rd_off_d  = rd_off_q + CW'(1);
				end
			end
			S_SHIFT: begin
				// read one entry ahead, write it one slot back
				if (rd_off_q < count_q) begin
					sh_d     = 1'b1;
					rd_off_d = rd_off_q + CW'(1);
				end else begin
					sh_d = 1'b0;
				end
				if (sh_s1) begin
					mem_we   = 1'b1;
					wr_off_d = wr_off_q + CW'(1);
					if (wr_off_q == count_q - CW'(2)) begin
						count_d = count_q - CW'(1);
						sh_d    = 1'b0;
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					rd_off_d = '0;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		out_w.out_proc_id     = res_q.ent.proc_id;
		out_w.out_progress    = res_q.ent.progress;
		out_w.out_level_id    = res_q.ent.level_id;
		out_w.out_burst_count = res_q.ent.burst_count;
		out_w.out_burst_a     = res_q.ent.bursts[0];
		out_w.out_burst_b     = res_q.ent.bursts[1];
		out_w.out_burst_c     = res_q.ent.bursts[2];
		out_w.out_burst_d     = res_q.ent.bursts[3];
		out_w.time_to_io      = res_q.tio;
		out_w.occupancy       = OCC_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			rd_off_q   <= '0;
			wr_off_q   <= '0;
			cmp_s1     <= 1'b0;
			cmp_off_s1 <= '0;
			sh_s1      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			head_q     <= head_d;
			count_q    <= count_d;
			rd_off_q   <= rd_off_d;
			wr_off_q   <= wr_off_d;
			cmp_s1     <= cmp_d;
			cmp_off_s1 <= cmp_off_d;
			sh_s1      <= sh_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		id_q  <= id_d;
		res_q <= res_d;
		if (load_out) begin
			m_tdata_q <= out_w;
			m_tuser_q <= res_q.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_RESP))
		else $error("result word raised outside the response step");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("retrieve did not drop the entry count");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && sh_s1) |-> (wr_off_q < count_q - CW'(1)))
		else $error("compaction write past the last live slot");

endmodule

>>> rtl/core/rqr_mem.sv
module rqr_mem
	import rqr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int AW    = $clog2(QUEUE_DEPTH_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/rqr_tio.sv
module rqr_tio
	import rqr_pkg::*;
(
	input  entry_t           ent,
	output logic [TIO_W-1:0] tio
);

	// first prefix sum past the progress, less the progress; NO_IO_TIME if none
	function automatic logic [TIO_W-1:0] time_left(input entry_t e);
		logic [PROG_W-1:0] sum;
		logic              found;
		logic [TIO_W-1:0]  res;
		sum   = '0;
		found = 1'b0;
		res   = NO_IO_TIME;
		for (int k = 0; k < NBURST; k++) begin
			if (!found && (CNT_W'(k) < e.burst_count)) begin
				sum = sum + PROG_W'(e.bursts[k]);
				if (sum > e.progress) begin
					res   = TIO_W'(sum - e.progress);
					found = 1'b1;
				end
			end
		end
		return res;
	endfunction

	assign tio = time_left(ent);

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import rqr_pkg::*;

	localparam int DEPTH        = QUEUE_DEPTH_DEF;
	localparam int BURST_LIMIT  = MAX_BURSTS_DEF;
	localparam int RANDOM_ITEMS = 850;
	localparam int QUIET_ITEMS  = 120;
	localparam int PAUSE_AT     = 300;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		status_t   sts;
		out_data_t d;
	} queue_result_t;

	typedef struct {
		op_t      op;
		in_data_t w;
		int       reps;
		bit       typed;
		status_t  sts;
		int       occ;
	} stim_row_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic [OP_W-1:0]  s_tuser  = OP_INSERT;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [STS_W-1:0] m_tuser;

	entry_t        ready_q[$];
	queue_result_t result_q[$];
	stim_row_t     stim_rows[$];
	int            errors    = 0;
	int            n_checked = 0;
	int            op_count[4];
	int            stall_left = 0;
	logic          no_idle = 1'b0;
	bit            quiet = 1'b0;

	ready_queue_with_removal_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int got, input int exp);
		if (got != exp) begin
			report($sformatf("%s got %0d, expected %0d", name, got, exp));
		end
	endtask

	function automatic in_data_t make_word(int id, int prog, int lvl, int cnt,
			int ba, int bb, int bc, int bd);
		in_data_t w;
		w             = '0;
		w.proc_id     = id[ID_W-1:0];
		w.progress    = prog[PROG_W-1:0];
		w.level_id    = lvl[LVL_W-1:0];
		w.burst_count = cnt[CNT_IN_W-1:0];
		w.burst_a     = ba[BURST_W-1:0];
		w.burst_b     = bb[BURST_W-1:0];
		w.burst_c     = bc[BURST_W-1:0];
		w.burst_d     = bd[BURST_W-1:0];
		return w;
	endfunction

	// Queue behaviour: append, pop the head with its time to I/O, or delete by id.
	function automatic queue_result_t predict_result(op_t op, in_data_t w);
		queue_result_t r;
		entry_t        e;
		logic [BURST_W-1:0] b_in [NBURST];
		int  sum;
		int  idx;
		bit  hit;
		r = '0;
		b_in[0] = w.burst_a;
		b_in[1] = w.burst_b;
		b_in[2] = w.burst_c;
		b_in[3] = w.burst_d;
		case (op)
			OP_INSERT, OP_REINSERT: begin
				if (w.burst_count > BURST_LIMIT) begin
					r.sts = STS_BURSTS;
				end else if (ready_q.size() >= DEPTH) begin
					r.sts = STS_FULL;
				end else begin
					e             = '0;
					e.proc_id     = w.proc_id;
					e.progress    = (op == OP_REINSERT) ? w.progress : '0;
					e.level_id    = w.level_id;
					e.burst_count = w.burst_count[CNT_W-1:0];
					for (int k = 0; k < NBURST; k++) begin
						e.bursts[k] = (k < w.burst_count) ? b_in[k] : '0;
					end
					ready_q.push_back(e);
					r.sts = STS_OK;
				end
			end
			OP_RETRIEVE: begin
				if (ready_q.size() == 0) begin
					r.sts = STS_EMPTY;
				end else begin
					e   = ready_q.pop_front();
					sum = 0;
					hit = 1'b0;
					r.d.time_to_io = NO_IO_TIME;
					for (int k = 0; k < NBURST; k++) begin
						if (!hit && k < e.burst_count) begin
							sum += e.bursts[k];
							if (sum > e.progress) begin
								r.d.time_to_io = TIO_W'(sum - e.progress);
								hit = 1'b1;
							end
						end
					end
					r.sts               = STS_OK;
					r.d.out_proc_id     = e.proc_id;
					r.d.out_progress    = e.progress;
					r.d.out_level_id    = e.level_id;
					r.d.out_burst_count = e.burst_count;
					r.d.out_burst_a     = e.bursts[0];
					r.d.out_burst_b     = e.bursts[1];
					r.d.out_burst_c     = e.bursts[2];
					r.d.out_burst_d     = e.bursts[3];
				end
			end
			default: begin
				if (ready_q.size() == 0) begin
					r.sts = STS_EMPTY;
				end else begin
					idx = -1;
					for (int k = 0; k < ready_q.size(); k++) begin
						if (idx < 0 && ready_q[k].proc_id == w.proc_id) begin
							idx = k;
						end
					end
					if (idx < 0) begin
						r.sts = STS_NOTFOUND;
					end else begin
						ready_q.delete(idx);
						r.sts           = STS_OK;
						r.d.out_proc_id = w.proc_id;
					end
				end
			end
		endcase
		r.d.occupancy = OCC_W'(ready_q.size());
		return r;
	endfunction

	// Mix of zero, all ones, small and full-range values.
	function automatic int rand_field(int width, int small_max);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return 0;
		end else if (r < 16) begin
			return (1 << width) - 1;
		end else if (r < 55) begin
			return $urandom_range(0, small_max);
		end
		return $urandom & ((1 << width) - 1);
	endfunction

	task automatic send_word(input op_t op, input in_data_t w, input bit typed,
			input status_t sts, input int occ);
		queue_result_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= op;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		r = predict_result(op, w);
		if (typed) begin
			r             = '0;
			r.sts         = sts;
			r.d.occupancy = OCC_W'(occ);
		end
		result_q.push_back(r);
		op_count[op]++;
	endtask

	task automatic add_row(input op_t op, input in_data_t w, input int reps,
			input bit typed, input status_t sts, input int occ);
		stim_row_t row;
		row.op    = op;
		row.w     = w;
		row.reps  = reps;
		row.typed = typed;
		row.sts   = sts;
		row.occ   = occ;
		stim_rows.push_back(row);
	endtask

	// Receiver: stall in short bursts, none once the quiet stretch starts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		queue_result_t exp_r;
		out_data_t     got;
		if (arst_n && m_tvalid && m_tready) begin
			got = out_data_t'(m_tdata);
			if (result_q.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				exp_r = result_q.pop_front();
				n_checked++;
				check_field("status", m_tuser, exp_r.sts);
				check_field("out_proc_id", got.out_proc_id, exp_r.d.out_proc_id);
				check_field("out_progress", got.out_progress, exp_r.d.out_progress);
				check_field("out_level_id", got.out_level_id, exp_r.d.out_level_id);
				check_field("out_burst_count", got.out_burst_count,
					exp_r.d.out_burst_count);
				check_field("out_burst_a", got.out_burst_a, exp_r.d.out_burst_a);
				check_field("out_burst_b", got.out_burst_b, exp_r.d.out_burst_b);
				check_field("out_burst_c", got.out_burst_c, exp_r.d.out_burst_c);
				check_field("out_burst_d", got.out_burst_d, exp_r.d.out_burst_d);
				check_field("time_to_io", got.time_to_io, exp_r.d.time_to_io);
				check_field("occupancy", got.occupancy, exp_r.d.occupancy);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		op_t      op;
		in_data_t w;
		int       waited;
		bit       fill_mode;
		int       r;
		int       pick;

		foreach (op_count[k]) op_count[k] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue after reset
		add_row(OP_RETRIEVE, make_word(0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STS_EMPTY, 0);
		add_row(OP_REMOVE, make_word(5, 0, 0, 0, 0, 0, 0, 0), 1, 1, STS_EMPTY, 0);
		// all-ones fields, four bursts; insert ignores the progress
		add_row(OP_INSERT, make_word(16'hFFFF, 4095, 7, 4, 1023, 1023, 1023, 1023), 1, 1,
			STS_OK, 1);
		// burst count over the limit
		add_row(OP_INSERT, make_word(3, 0, 1, 5, 1, 2, 3, 4), 1, 1, STS_BURSTS, 1);
		add_row(OP_REINSERT, make_word(4, 9, 2, 15, 1, 2, 3, 4), 1, 1, STS_BURSTS, 1);
		// no bursts, unused lengths dropped
		add_row(OP_REINSERT, make_word(0, 4095, 0, 0, 511, 77, 1023, 1), 1, 0, STS_OK, 0);
		add_row(OP_REINSERT, make_word(16'h1234, 100, 3, 2, 50, 60, 900, 900), 1, 0,
			STS_OK, 0);
		add_row(OP_INSERT, make_word(7, 0, 4, 1, 0, 5, 5, 5), 1, 0, STS_OK, 0);
		// bursts never pass the progress, then first pass it at the third burst
		add_row(OP_REINSERT, make_word(8, 4095, 5, 4, 1023, 1023, 1023, 1023), 1, 0,
			STS_OK, 0);
		add_row(OP_REINSERT, make_word(9, 3000, 6, 4, 1023, 1023, 1023, 1023), 1, 0,
			STS_OK, 0);
		add_row(OP_REMOVE, make_word(16'h1234, 0, 0, 0, 0, 0, 0, 0), 1, 0, STS_OK, 0);
		add_row(OP_REMOVE, make_word(77, 0, 0, 0, 0, 0, 0, 0), 1, 1, STS_NOTFOUND, 5);
		add_row(OP_REMOVE, make_word(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, STS_OK, 0);
		// fill to the top, then hit full and the burst check ahead of it
		add_row(OP_INSERT, make_word(16'h0100, 0, 2, 3, 10, 20, 30, 0), 12, 0, STS_OK, 0);
		add_row(OP_INSERT, make_word(16'h0200, 0, 1, 1, 1, 0, 0, 0), 1, 1, STS_FULL, 16);
		add_row(OP_REINSERT, make_word(16'h0201, 5, 1, 2, 1, 1, 0, 0), 1, 1, STS_FULL, 16);
		add_row(OP_REINSERT, make_word(16'h0202, 5, 1, 6, 1, 1, 0, 0), 1, 1, STS_BURSTS, 16);
		add_row(OP_REMOVE, make_word(16'h010B, 0, 0, 0, 0, 0, 0, 0), 1, 0, STS_OK, 0);
		add_row(OP_RETRIEVE, make_word(0, 0, 0, 0, 0, 0, 0, 0), 4, 0, STS_OK, 0);

		foreach (stim_rows[i]) begin
			for (int k = 0; k < stim_rows[i].reps; k++) begin
				w = stim_rows[i].w;
				w.proc_id = w.proc_id + ID_W'(k);
				send_word(stim_rows[i].op, w, stim_rows[i].typed, stim_rows[i].sts,
					stim_rows[i].occ);
			end
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
				quiet = 1'b1;
				no_idle <= 1'b1;
			end
			if (i == PAUSE_AT) begin
				// hold until the queue of results has drained
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (result_q.size() != 0) @(posedge clk);
			end
			fill_mode = ((i / 50) % 2) == 0;
			r = $urandom_range(0, 99);
			if (r < 5) begin
				op = op_t'($urandom_range(0, 3));
				w  = in_data_t'({$urandom, $urandom, $urandom});
				w.pad = '0;
			end else begin
				r = $urandom_range(0, 99);
				if (fill_mode) begin
					op = (r < 35) ? OP_INSERT : (r < 65) ? OP_REINSERT :
						(r < 85) ? OP_RETRIEVE : OP_REMOVE;
				end else begin
					op = (r < 10) ? OP_INSERT : (r < 20) ? OP_REINSERT :
						(r < 65) ? OP_RETRIEVE : OP_REMOVE;
				end
				w = make_word(rand_field(ID_W, 6), rand_field(PROG_W, 300),
					$urandom_range(0, 7),
					($urandom_range(0, 99) < 88) ? $urandom_range(0, BURST_LIMIT) :
						$urandom_range(BURST_LIMIT + 1, 15),
					rand_field(BURST_W, 100), rand_field(BURST_W, 100),
					rand_field(BURST_W, 100), rand_field(BURST_W, 100));
				// remove mostly names an id that is waiting
				if (op == OP_REMOVE && ready_q.size() != 0 && $urandom_range(0, 3) != 0) begin
					pick = $urandom_range(0, ready_q.size() - 1);
					w.proc_id = ready_q[pick].proc_id;
				end
			end
			send_word(op, w, 1'b0, STS_OK, 0);
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (result_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (result_q.size() != 0) begin
			report($sformatf("%0d results never arrived", result_q.size()));
		end

		$display("Covered %0d inserts, %0d reinserts, %0d retrieves, %0d removes",
			op_count[OP_INSERT], op_count[OP_REINSERT], op_count[OP_RETRIEVE],
			op_count[OP_REMOVE]);
		$display("%0d result words compared, %0d mismatches", n_checked, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/rqr_pkg.sv
rtl/core/rqr_mem.sv
rtl/core/rqr_tio.sv
rtl/core/ready_queue_with_removal_core.sv
bench/tb.sv
